[rtl/lct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types for the LRU cache table: operation codes and the op record
// that travels down the cell chain.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned WIDX_W  = 7;   // wide enough for any slot index and ENTRIES

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                vld;
    kind_t               kind;
    logic [VALUE_W-1:0]  key;
    logic [SLOT_W-1:0]   slot;
  } lct_op_t;

endpackage
`default_nettype wire

[rtl/lct_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lct_cell
// One table entry. Holds value, valid and stamp, and folds its entry into the
// scan record handed on to the next cell each cycle.
// ----------------------------------------------------------------------------
module lct_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IW    = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lct_pkg::lct_op_t                op_i,
  input  wire logic                            found_i,
  input  wire logic [IW-1:0]                   idx_i,
  input  wire logic [lct_pkg::STAMP_W-1:0]     stamp_i,
  input  wire logic [lct_pkg::VALUE_W-1:0]     value_i,
  output lct_pkg::lct_op_t                     op_o,
  output logic                                 found_o,
  output logic [IW-1:0]                        idx_o,
  output logic [lct_pkg::STAMP_W-1:0]          stamp_o,
  output logic [lct_pkg::VALUE_W-1:0]          value_o,
  input  wire logic                            wr_en,
  input  wire logic [lct_pkg::VALUE_W-1:0]     wr_value,
  input  wire logic [lct_pkg::STAMP_W-1:0]     wr_stamp
);
  import lct_pkg::*;

  logic [VALUE_W-1:0] value_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               valid_r;

  lct_op_t            op_r;
  logic               found_r, found_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [STAMP_W-1:0] sstamp_r, sstamp_nxt;
  logic [VALUE_W-1:0] svalue_r, svalue_nxt;
  logic               slot_match;

  assign slot_match = ({{(WIDX_W-SLOT_W){1'b0}}, op_i.slot} == WIDX_W'(INDEX));

  always_comb begin
    found_nxt  = found_i;
    idx_nxt    = idx_i;
    sstamp_nxt = stamp_i;
    svalue_nxt = value_i;
    if (op_i.vld) begin
      case (op_i.kind)
        KIND_LOOKUP: begin
          if (!found_i && valid_r && value_r == op_i.key) begin
            found_nxt  = 1'b1;
            idx_nxt    = IW'(INDEX);
            svalue_nxt = value_r;
          end
        end
        KIND_PUSH: begin
          // strict less-than keeps the lowest slot on ties
          if (!found_i || stamp_r < stamp_i) begin
            found_nxt  = 1'b1;
            idx_nxt    = IW'(INDEX);
            sstamp_nxt = stamp_r;
          end
        end
        KIND_READ: begin
          if (slot_match) begin
            svalue_nxt = value_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
      op_r    <= '0;
    end else begin
      op_r <= op_i;
      if (wr_en) begin
        valid_r <= 1'b1;
        stamp_r <= wr_stamp;
      end
    end
    if (wr_en) begin
      value_r <= wr_value;
    end
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    sstamp_r <= sstamp_nxt;
    svalue_r <= svalue_nxt;
  end

  assign op_o    = op_r;
  assign found_o = found_r;
  assign idx_o   = idx_r;
  assign stamp_o = sstamp_r;
  assign value_o = svalue_r;

endmodule
`default_nettype wire

[rtl/lru_cache_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_table
// Fully associative table of ENTRIES 32-bit values, least recently written
// replaced first by stamp; a chain of entry cells scanned one cell per cycle.
//
//   channel | dir | tdata (low to high)        | tuser
//   in_     | in  | value[31:0], slot[34:32]   | kind[1:0]
//   out_    | out | slot_out[2:0], value[34:3] | hit[0]
//
// Each transfer ripples the op through the cell chain, captures the tail,
// then writes back and loads the result register. One item is in flight
// at a time; a held result stalls the write-back and, with it, the next
// input transfer, as input is taken only in idle.
// Synchronous active-low reset clears valid bits, stamps, counters and FSM.
// ----------------------------------------------------------------------------
module lru_cache_table #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], slot[34:32], zero pad
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // slot_out[2:0], value_out[34:3], zero pad
  output logic [0:0]       out_tuser   // hit[0]
);
  import lct_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned FW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t             state_r;
  logic [FW-1:0]      fill_r;
  logic [STAMP_W-1:0] cnt_r;
  logic               out_tvalid_r;
  logic [39:0]        out_tdata_r;
  logic [0:0]         out_tuser_r;

  lct_op_t            tail_op_r;
  logic               tail_found_r;
  logic [IW-1:0]      tail_idx_r;
  logic [VALUE_W-1:0] tail_value_r;

  lct_op_t            op_c    [0:ENTRIES];
  logic               found_c [0:ENTRIES];
  logic [IW-1:0]      idx_c   [0:ENTRIES];
  logic [STAMP_W-1:0] stamp_c [0:ENTRIES];
  logic [VALUE_W-1:0] value_c [0:ENTRIES];

  logic               in_xfer;
  logic               fin_go;
  logic               do_wr;
  logic [WIDX_W-1:0]  wr_idx;
  logic               res_hit;
  logic [VALUE_W-1:0] res_value;
  logic [STAMP_W-1:0] wr_stamp;
  logic               slot_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign fin_go    = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign wr_stamp  = cnt_r + STAMP_W'(1);
  assign slot_ok   = ({{(WIDX_W-SLOT_W){1'b0}}, tail_op_r.slot} < WIDX_W'(ENTRIES));

  always_comb begin
    op_c[0].vld  = in_xfer;
    op_c[0].kind = kind_t'(in_tuser);
    op_c[0].key  = in_tdata[31:0];
    op_c[0].slot = in_tdata[34:32];
    found_c[0]   = 1'b0;
    idx_c[0]     = '0;
    stamp_c[0]   = '0;
    value_c[0]   = '0;
  end

  always_comb begin
    do_wr     = 1'b0;
    wr_idx    = {{(WIDX_W-SLOT_W){1'b0}}, tail_op_r.slot};
    res_hit   = 1'b1;
    res_value = '0;
    case (tail_op_r.kind)
      KIND_PUSH: begin
        do_wr     = 1'b1;
        wr_idx    = (fill_r < FW'(ENTRIES)) ? WIDX_W'(fill_r) : WIDX_W'(tail_idx_r);
        res_value = tail_op_r.key;
      end
      KIND_UPDATE: begin
        do_wr     = slot_ok;
        res_value = slot_ok ? tail_op_r.key : '0;
      end
      KIND_LOOKUP: begin
        res_hit   = tail_found_r;
        wr_idx    = tail_found_r ? WIDX_W'(tail_idx_r) : '0;
        res_value = tail_found_r ? tail_value_r : '0;
      end
      KIND_READ: begin
        res_value = tail_value_r;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lct_cell #(
      .INDEX (g),
      .IW    (IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op_i     (op_c[g]),
      .found_i  (found_c[g]),
      .idx_i    (idx_c[g]),
      .stamp_i  (stamp_c[g]),
      .value_i  (value_c[g]),
      .op_o     (op_c[g+1]),
      .found_o  (found_c[g+1]),
      .idx_o    (idx_c[g+1]),
      .stamp_o  (stamp_c[g+1]),
      .value_o  (value_c[g+1]),
      .wr_en    (fin_go && do_wr && (wr_idx == WIDX_W'(g))),
      .wr_value (tail_op_r.key),
      .wr_stamp (wr_stamp)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !fin_go) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_c[ENTRIES].vld) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b1;
            if (do_wr) begin
              cnt_r <= wr_stamp;
            end
            if (tail_op_r.kind == KIND_PUSH && fill_r < FW'(ENTRIES)) begin
              fill_r <= fill_r + FW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (state_r == S_SCAN && op_c[ENTRIES].vld) begin
      tail_op_r    <= op_c[ENTRIES];
      tail_found_r <= found_c[ENTRIES];
      tail_idx_r   <= idx_c[ENTRIES];
      tail_value_r <= value_c[ENTRIES];
    end
    if (fin_go) begin
      out_tdata_r <= {5'd0, res_value, wr_idx[SLOT_W-1:0]};
      out_tuser_r <= res_hit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

[tb/tb_lru_cache_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_table
// Self-checking bench for the LRU cache table. A directed sequence fills the
// table, hits duplicate and missing values and forces evictions; random
// traffic follows. A scoreboard keeps its own copy of the table and the
// stamp counter and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_lru_cache_table;
  import lct_pkg::*;

  localparam int unsigned NUM_SLOTS    = 8;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CALM_ITEMS   = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 4 * (NUM_SLOTS + 2);
  localparam int unsigned POOL_DEPTH   = 16;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } table_result_t;

  class lru_scoreboard;
    logic [VALUE_W-1:0] value_mem [NUM_SLOTS];
    bit                 valid_mem [NUM_SLOTS];
    logic [STAMP_W-1:0] stamp_mem [NUM_SLOTS];
    logic [STAMP_W-1:0] stamp_cnt;
    int unsigned        fill_cnt;
    table_result_t      pending_q [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        value_mem[i] = '0;
        valid_mem[i] = 1'b0;
        stamp_mem[i] = '0;
      end
      stamp_cnt = '0;
      fill_cnt  = 0;
      errors    = 0;
    endfunction

    function void store(int unsigned idx, logic [VALUE_W-1:0] v);
      stamp_cnt      = stamp_cnt + 1'b1;
      value_mem[idx] = v;
      valid_mem[idx] = 1'b1;
      stamp_mem[idx] = stamp_cnt;
    endfunction

    // smallest stamp, lowest slot on ties
    function int unsigned oldest_slot();
      int unsigned best;
      best = 0;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (stamp_mem[i] < stamp_mem[best]) best = i;
      end
      return best;
    endfunction

    function void note_input(kind_t kind, logic [VALUE_W-1:0] v, logic [SLOT_W-1:0] s);
      table_result_t r;
      int unsigned   idx;
      r.hit   = 1'b1;
      r.slot  = '0;
      r.value = '0;
      case (kind)
        KIND_PUSH: begin
          if (fill_cnt < NUM_SLOTS) begin
            idx      = fill_cnt;
            fill_cnt = fill_cnt + 1;
          end else begin
            idx = oldest_slot();
          end
          store(idx, v);
          r.slot  = SLOT_W'(idx);
          r.value = v;
        end
        KIND_UPDATE: begin
          r.slot = s;
          if (s < NUM_SLOTS) begin
            store(s, v);
            r.value = v;
          end
        end
        KIND_LOOKUP: begin
          r.hit = 1'b0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (valid_mem[i] && value_mem[i] == v) begin
              r.hit   = 1'b1;
              r.slot  = SLOT_W'(i);
              r.value = v;
              break;
            end
          end
        end
        default: begin
          r.slot = s;
          if (s < NUM_SLOTS) r.value = value_mem[s];
        end
      endcase
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors = errors + 1;
    endtask

    task check_result(logic hit, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value);
      table_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected transfer hit=%0b slot=%0d value=%h", hit, slot, value));
      end else begin
        exp_r = pending_q.pop_front();
        if (hit !== exp_r.hit)
          report($sformatf("hit got %0b exp %0b", hit, exp_r.hit));
        if (slot !== exp_r.slot)
          report($sformatf("slot_out got %0d exp %0d", slot, exp_r.slot));
        if (value !== exp_r.value)
          report($sformatf("value_out got %h exp %h", value, exp_r.value));
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // value[31:0], slot[34:32], zero pad
  logic [1:0]  in_tuser   = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // slot_out[2:0], value_out[34:3], zero pad
  logic [0:0]  out_tuser;         // hit[0]

  lru_scoreboard      sb;
  bit                 idle_en   = 1'b0;
  bit                 hold_req  = 1'b0;
  bit                 gen_written [NUM_SLOTS];
  int unsigned        gen_fill  = 0;
  logic [VALUE_W-1:0] value_pool [$];
  int unsigned        stall_cycles = 0;

  lru_cache_table #(.ENTRIES(NUM_SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(kind_t'(in_tuser), in_tdata[31:0], in_tdata[34:32]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser[0], out_tdata[2:0], out_tdata[34:3]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: random back-pressure plus one long hold
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task send_item(kind_t kind, logic [VALUE_W-1:0] v, logic [SLOT_W-1:0] s);
    if (kind == KIND_PUSH && gen_fill < NUM_SLOTS) begin
      gen_written[gen_fill] = 1'b1;
      gen_fill = gen_fill + 1;
    end
    if (kind == KIND_UPDATE) gen_written[s] = 1'b1;
    if (kind == KIND_PUSH || kind == KIND_UPDATE) begin
      value_pool.push_back(v);
      if (value_pool.size() > POOL_DEPTH) void'(value_pool.pop_front());
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, s, v};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task send_random();
    kind_t              kind;
    logic [VALUE_W-1:0] v;
    logic [SLOT_W-1:0]  s;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      kind = KIND_PUSH;
    else if (pick < 55) kind = KIND_UPDATE;
    else if (pick < 85) kind = KIND_LOOKUP;
    else                kind = KIND_READ;
    s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    case ($urandom_range(0, 2))
      0: v = $urandom;
      1: v = VALUE_W'($urandom_range(0, 7));   // small values give duplicates
      default: begin
        if (value_pool.size() > 0)
          v = value_pool[$urandom_range(0, value_pool.size() - 1)];
        else
          v = $urandom;
      end
    endcase
    // never read a slot that has not been written
    if (kind == KIND_READ && !gen_written[s]) kind = KIND_LOOKUP;
    send_item(kind, v, s);
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < NUM_SLOTS; i++) gen_written[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, pre-fill update, fill with duplicates, then evictions
    send_item(KIND_LOOKUP, 32'h0000_0000, 3'd0);
    send_item(KIND_PUSH,   32'hFFFF_FFFF, 3'd7);
    send_item(KIND_UPDATE, 32'h0000_0000, 3'd5);
    send_item(KIND_READ,   32'hFFFF_FFFF, 3'd5);
    send_item(KIND_LOOKUP, 32'h0000_0000, 3'd7);
    send_item(KIND_PUSH,   32'hA5A5_A5A5, 3'd0);
    send_item(KIND_PUSH,   32'h5A5A_5A5A, 3'd0);
    send_item(KIND_PUSH,   32'hFFFF_FFFF, 3'd0);
    send_item(KIND_PUSH,   32'h0000_0001, 3'd0);
    send_item(KIND_PUSH,   32'h0000_0002, 3'd0);
    send_item(KIND_PUSH,   32'h0000_0003, 3'd0);
    send_item(KIND_PUSH,   32'h8000_0000, 3'd0);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 3'd0);
    send_item(KIND_LOOKUP, 32'h0000_0000, 3'd0);
    send_item(KIND_PUSH,   32'h1234_5678, 3'd0);
    send_item(KIND_UPDATE, 32'hDEAD_BEEF, 3'd7);
    send_item(KIND_UPDATE, 32'h0000_0001, 3'd2);
    send_item(KIND_READ,   32'h0000_0000, 3'd7);
    send_item(KIND_READ,   32'h0000_0000, 3'd0);
    send_item(KIND_READ,   32'h0000_0000, 3'd3);
    send_item(KIND_PUSH,   32'h7FFF_FFFF, 3'd0);
    send_item(KIND_PUSH,   32'h0F0F_0F0F, 3'd0);
    send_item(KIND_LOOKUP, 32'h0000_0001, 3'd0);
    send_item(KIND_LOOKUP, 32'h1234_5678, 3'd0);

    idle_en  = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_en = 1'b0;
      send_random();
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/lct_pkg.sv
rtl/lct_cell.sv
rtl/lru_cache_table.sv
tb/tb_lru_cache_table.sv
